/* rtl/glyph_quad_text_layout_defines.svh */
`ifndef GLYPH_QUAD_TEXT_LAYOUT_DEFINES_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define GQTL_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("gqtl: invariant violated");

// condition that must hold whenever the antecedent holds
`define GQTL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gqtl: implication violated");

`endif

/* rtl/gqtl_pkg.sv */
package gqtl_pkg;

  localparam int SLOT_COUNT = 96;
  localparam int SLOT_W = 7;
  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0] SLOT_OFFSET = 8'h1F;
  localparam logic [7:0] HIGH_BYTE = 8'h80;
  localparam logic [7:0] BLANK_BYTE = 8'h01;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int IN_TDATA_W = 128;
  localparam int OUT_TDATA_W = 72;
  localparam int BEATS = 6;
  localparam int BEAT_W = 3;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic RES_VERTEX = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  typedef struct packed {
    logic signed [10:0] bx;
    logic signed [10:0] by;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [7:0]         adv;
    logic [11:0]        ax;
    logic [11:0]        ay;
  } glyph_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               blank;
    glyph_t             g;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic [14:0]        clip;
  } op_t;

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    logic [15:0] r;
    if (v > 19'sd32767) r = 16'h7FFF;
    else if (v < -19'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [11:0] sat12(input logic [12:0] v);
    return v[12] ? 12'hFFF : v[11:0];
  endfunction

  // {use right column, use bottom row} for each beat: corners 0,1,2 then 0,2,3
  function automatic logic [1:0] corner_sel(input logic [BEAT_W-1:0] beat);
    logic [1:0] s;
    case (beat)
      3'd0: s = 2'b00;
      3'd1: s = 2'b10;
      3'd2: s = 2'b11;
      3'd3: s = 2'b00;
      3'd4: s = 2'b11;
      3'd5: s = 2'b01;
      default: s = 2'b00;
    endcase
    return s;
  endfunction

endpackage

/* rtl/gqtl_front.sv */
module gqtl_front import gqtl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // code, bearing_x, bearing_y, glyph_width, glyph_height, advance,
  // atlas_x, atlas_y, pen_x, pen_y, clip_width
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // kind
  input  logic [1:0]            in_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output op_t                   push_op
);

  logic [7:0]        code;
  glyph_t            wr_glyph;
  logic [SLOT_W-1:0] slot;
  logic              accept;

  glyph_t            glyph_mem_r [SLOT_COUNT];
  glyph_t            rd_glyph_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_kind_r;
  logic              s1_blank_r;
  logic [15:0]       s1_pen_x_r;
  logic [15:0]       s1_pen_y_r;
  logic [14:0]       s1_clip_r;

  assign code = in_tdata[7:0];
  assign wr_glyph = '{bx: in_tdata[18:8], by: in_tdata[29:19], w: in_tdata[37:30],
                      h: in_tdata[45:38], adv: in_tdata[53:46], ax: in_tdata[65:54],
                      ay: in_tdata[77:66]};

  always_comb begin
    if (code < FIRST_PRINTABLE || code >= HIGH_BYTE - 8'd1) begin
      slot = '0;
    end else begin
      slot = SLOT_W'(code - SLOT_OFFSET);
    end
  end

  assign in_tready = !s1_valid_r || push_ready;
  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (accept && in_tuser == KIND_LOAD && code < 8'(SLOT_COUNT)) begin
      glyph_mem_r[code[SLOT_W-1:0]] <= wr_glyph;
    end
    if (accept && in_tuser == KIND_CHAR) begin
      rd_glyph_r <= glyph_mem_r[slot];
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = (in_tuser != KIND_LOAD);
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= in_tuser;
      s1_blank_r <= (code == BLANK_BYTE);
      s1_pen_x_r <= in_tdata[93:78];
      s1_pen_y_r <= in_tdata[109:94];
      s1_clip_r  <= in_tdata[124:110];
    end
  end

  assign push_valid = s1_valid_r;
  assign push_op = '{kind: s1_kind_r, blank: s1_blank_r, g: rd_glyph_r,
                     pen_x: s1_pen_x_r, pen_y: s1_pen_y_r, clip: s1_clip_r};

endmodule

/* rtl/gqtl_queue.sv */
module gqtl_queue import gqtl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  op_t              push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output op_t              pop_op,
  output logic [CNT_W-1:0] count
);

  op_t              slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;
  assign pop_op = slot_r[rd_ptr_r];
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* rtl/gqtl_back.sv */
module gqtl_back import gqtl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data,
  input  logic                   op_valid,
  output logic                   op_ready,
  input  op_t                    op,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vertex_x, vertex_y, tex_x, tex_y, drawn_width
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // result_kind
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [7:0]        fps_r;

  logic [15:0]       pen_x_r, pen_x_nxt;
  logic [15:0]       pen_y_r, pen_y_nxt;
  logic [15:0]       pen_start_r, pen_start_nxt;
  logic [14:0]       clip_r, clip_nxt;
  logic              clipped_r, clipped_nxt;

  logic              job_valid_r, job_valid_nxt;
  logic              job_rep_r, job_rep_nxt;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic [15:0]       x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [11:0]       u0_r, u0_nxt, u1_r, u1_nxt, v0_r, v0_nxt, v1_r, v1_nxt;
  logic [15:0]       dw_r, dw_nxt;

  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic              out_tuser_r, out_tlast_r;

  logic              out_load, job_done, pop;
  logic signed [16:0] next_x;
  logic signed [18:0] x0_raw, x1_raw, y0_raw, y1_raw;
  logic              clip_hit;
  logic [1:0]        sel;

  assign cfg_ready = 1'b1;

  // geometry of the glyph at the current pen
  assign next_x = {pen_x_r[15], pen_x_r} + {9'd0, op.g.adv};
  assign x0_raw = {{3{pen_x_r[15]}}, pen_x_r} + {{8{op.g.bx[10]}}, op.g.bx};
  assign x1_raw = x0_raw + {11'd0, op.g.w};
  assign y0_raw = {{3{pen_y_r[15]}}, pen_y_r} + {11'd0, fps_r} - {{8{op.g.by[10]}}, op.g.by};
  assign y1_raw = y0_raw + {11'd0, op.g.h};
  assign clip_hit = (clip_r != '0) && (next_x > $signed({2'b00, clip_r}));

  assign out_load = job_valid_r && (!out_tvalid_r || out_tready);
  assign job_done = out_load && (job_rep_r || beat_r == BEAT_W'(BEATS - 1));
  assign op_ready = !job_valid_r || job_done;
  assign pop = op_valid && op_ready;

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    pen_start_nxt = pen_start_r;
    clip_nxt = clip_r;
    clipped_nxt = clipped_r;
    job_valid_nxt = job_done ? 1'b0 : job_valid_r;
    job_rep_nxt = job_rep_r;
    beat_nxt = out_load ? beat_r + 1'b1 : beat_r;
    x0_nxt = x0_r;
    x1_nxt = x1_r;
    y0_nxt = y0_r;
    y1_nxt = y1_r;
    u0_nxt = u0_r;
    u1_nxt = u1_r;
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    dw_nxt = dw_r;
    if (pop) begin
      case (op.kind)
        KIND_START: begin
          pen_x_nxt = op.pen_x;
          pen_start_nxt = op.pen_x;
          pen_y_nxt = op.pen_y;
          clip_nxt = op.clip;
          clipped_nxt = 1'b0;
        end
        KIND_END: begin
          job_valid_nxt = 1'b1;
          job_rep_nxt = 1'b1;
          beat_nxt = '0;
          x0_nxt = pen_x_r;
          dw_nxt = pen_x_r - pen_start_r;
        end
        KIND_CHAR: begin
          if (!clipped_r) begin
            if (clip_hit) begin
              clipped_nxt = 1'b1;
            end else begin
              pen_x_nxt = sat16({{2{next_x[16]}}, next_x});
              if (!op.blank) begin
                job_valid_nxt = 1'b1;
                job_rep_nxt = 1'b0;
                beat_nxt = '0;
                x0_nxt = sat16(x0_raw);
                x1_nxt = sat16(x1_raw);
                y0_nxt = sat16(y0_raw);
                y1_nxt = sat16(y1_raw);
                u0_nxt = op.g.ax;
                v0_nxt = op.g.ay;
                u1_nxt = sat12({1'b0, op.g.ax} + {5'd0, op.g.w});
                v1_nxt = sat12({1'b0, op.g.ay} + {5'd0, op.g.h});
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r <= '0;
      pen_x_r <= '0;
      pen_y_r <= '0;
      pen_start_r <= '0;
      clip_r <= '0;
      clipped_r <= 1'b0;
      job_valid_r <= 1'b0;
      job_rep_r <= 1'b0;
      beat_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fps_r <= cfg_data;
      end
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      pen_start_r <= pen_start_nxt;
      clip_r <= clip_nxt;
      clipped_r <= clipped_nxt;
      job_valid_r <= job_valid_nxt;
      job_rep_r <= job_rep_nxt;
      beat_r <= beat_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign sel = corner_sel(beat_r);

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt;
    x1_r <= x1_nxt;
    y0_r <= y0_nxt;
    y1_r <= y1_nxt;
    u0_r <= u0_nxt;
    u1_r <= u1_nxt;
    v0_r <= v0_nxt;
    v1_r <= v1_nxt;
    dw_r <= dw_nxt;
    if (out_load) begin
      if (job_rep_r) begin
        out_tdata_r <= {dw_r, 12'd0, 12'd0, 16'd0, x0_r};
        out_tuser_r <= RES_REPORT;
        out_tlast_r <= 1'b1;
      end else begin
        out_tdata_r <= {16'd0, sel[0] ? v1_r : v0_r, sel[1] ? u1_r : u0_r,
                        sel[0] ? y1_r : y0_r, sel[1] ? x1_r : x0_r};
        out_tuser_r <= RES_VERTEX;
        out_tlast_r <= (beat_r == BEAT_W'(BEATS - 1));
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign out_tlast = out_tlast_r;

endmodule

/* rtl/glyph_quad_text_layout.sv */
// Text quad generator: turns a stream of glyph loads, string starts,
// character bytes and string ends into glyph vertices for two triangles.
// in_*  : input beats, kind in in_tuser; a load fills one of 96 glyph slots,
//         a start sets pen and clip, an unclipped non-blank character
//         emits six vertex beats, an end emits one width report beat.
// out_* : result beats, result kind in out_tuser, out_tlast on the final
//         beat caused by one input beat.
// cfg_* : font pixel size, always ready, to be written by the user while
//         the block is idle; the block itself does not enforce this.
// A character passes the glyph table read, queue, geometry stage and output
// register; its six vertices leave the single output port one at a time
// before the next starts. Loads and starts emit nothing and are taken every
// cycle while the queue between the front and the back part has room.
// Reset clears pen, clip, font size and all handshake state; the glyph
// table holds nothing valid until loaded. When the receiver stalls, the
// output register holds, then the queue fills and in_tready drops.
module glyph_quad_text_layout import gqtl_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // code, bearing_x, bearing_y, glyph_width, glyph_height, advance,
  // atlas_x, atlas_y, pen_x, pen_y, clip_width
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vertex_x, vertex_y, tex_x, tex_y, drawn_width
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // result_kind
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);

  `include "glyph_quad_text_layout_defines.svh"

  localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic               push_valid, push_ready;
  op_t                push_op;
  logic               q_pop_valid, q_pop_ready;
  op_t                q_pop_op;
  logic [Q_CNT_W-1:0] q_count;

  gqtl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  gqtl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_op     (q_pop_op),
    .count      (q_count)
  );

  gqtl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .op_valid   (q_pop_valid),
    .op_ready   (q_pop_ready),
    .op         (q_pop_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `GQTL_ASSERT_HOLDS(a_queue_bound, q_count <= Q_CNT_W'(QUEUE_DEPTH))
  `GQTL_ASSERT_IMPLIES(a_empty_no_pop, q_count == '0, !q_pop_valid)
  `GQTL_ASSERT_IMPLIES(a_report_last, out_tvalid && out_tuser == RES_REPORT, out_tlast)

endmodule

/* tb/glyph_quad_text_layout_tb.sv */
module glyph_quad_text_layout_tb;
  import gqtl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         kind;
    logic [7:0]         code;
    logic signed [10:0] bx;
    logic signed [10:0] by;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [7:0]         adv;
    logic [11:0]        ax;
    logic [11:0]        ay;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [14:0]        clip;
  } text_item_t;

  typedef struct {
    int bx;
    int by;
    int w;
    int h;
    int adv;
    int ax;
    int ay;
  } glyph_rec_t;

  typedef struct {
    logic        kind;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [11:0] tx;
    logic [11:0] ty;
    logic [15:0] dw;
    logic        last;
  } vertex_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_data;

  // layout state mirrored from the block
  glyph_rec_t   glyph_tab [SLOT_COUNT];
  bit           slot_loaded [SLOT_COUNT];
  int           pen_now;
  int           pen_base;
  int           pen_origin;
  int           clip_at;
  bit           clipped;
  int           font_px;

  vertex_beat_t pending_beats [$];
  int           err_count;
  int           items_sent;
  int           idle_pct;
  int           stall_pct;
  int           hold_off_cycles;

  glyph_quad_text_layout dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clamp12(input int v);
    return (v > 4095) ? 4095 : v;
  endfunction

  function automatic int slot_of(input logic [7:0] c);
    if (c < FIRST_PRINTABLE || c >= HIGH_BYTE - 8'd1) return 0;
    return int'(c - SLOT_OFFSET);
  endfunction

  function automatic text_item_t random_item();
    text_item_t it;
    it.kind = 2'($urandom_range(3));
    it.code = 8'($urandom_range(255));
    it.bx   = 11'($urandom);
    it.by   = 11'($urandom);
    it.w    = 8'($urandom);
    it.h    = 8'($urandom);
    it.adv  = 8'($urandom);
    it.ax   = 12'($urandom);
    it.ay   = 12'($urandom);
    it.px   = 16'($urandom);
    it.py   = 16'($urandom);
    it.clip = 15'($urandom);
    return it;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_item(input text_item_t it);
    return {3'b000, it.clip, it.py, it.px, it.ay, it.ax, it.adv, it.h, it.w,
            it.by, it.bx, it.code};
  endfunction

  task automatic report_mismatch(input string what, input logic [71:0] got,
                                 input logic [71:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic push_beat(input logic kind, input int x, input int y, input int tx,
                           input int ty, input int dw, input logic last);
    vertex_beat_t b;
    b.kind = kind;
    b.vx   = 16'(x);
    b.vy   = 16'(y);
    b.tx   = 12'(tx);
    b.ty   = 12'(ty);
    b.dw   = 16'(dw);
    b.last = last;
    pending_beats.push_back(b);
  endtask

  // expected beats for one accepted input beat
  task automatic lay_out(input text_item_t it);
    glyph_rec_t g;
    int slot, nxt, x0, x1, y0, y1, u0, u1, v0, v1;
    case (it.kind)
      KIND_LOAD: begin
        if (it.code < SLOT_COUNT) begin
          glyph_tab[it.code] = '{int'(it.bx), int'(it.by), int'(it.w), int'(it.h),
                                 int'(it.adv), int'(it.ax), int'(it.ay)};
          slot_loaded[it.code] = 1'b1;
        end
      end
      KIND_START: begin
        pen_now    = int'(it.px);
        pen_origin = pen_now;
        pen_base   = int'(it.py);
        clip_at    = int'(it.clip);
        clipped    = 1'b0;
      end
      KIND_END: begin
        push_beat(RES_REPORT, pen_now, 0, 0, 0, pen_now - pen_origin, 1'b1);
      end
      default: begin
        if (!clipped) begin
          slot = slot_of(it.code);
          g    = glyph_tab[slot];
          nxt  = pen_now + g.adv;
          if (clip_at != 0 && nxt > clip_at) begin
            clipped = 1'b1;
          end else if (it.code == BLANK_BYTE) begin
            pen_now = clamp16(nxt);
          end else begin
            x0 = clamp16(pen_now + g.bx);
            x1 = clamp16(pen_now + g.bx + g.w);
            y0 = clamp16(pen_base + font_px - g.by);
            y1 = clamp16(pen_base + font_px - g.by + g.h);
            u0 = g.ax;
            v0 = g.ay;
            u1 = clamp12(u0 + g.w);
            v1 = clamp12(v0 + g.h);
            // two triangles: corners 0,1,2 then 0,2,3
            push_beat(RES_VERTEX, x0, y0, u0, v0, 0, 1'b0);
            push_beat(RES_VERTEX, x1, y0, u1, v0, 0, 1'b0);
            push_beat(RES_VERTEX, x1, y1, u1, v1, 0, 1'b0);
            push_beat(RES_VERTEX, x0, y0, u0, v0, 0, 1'b0);
            push_beat(RES_VERTEX, x1, y1, u1, v1, 0, 1'b0);
            push_beat(RES_VERTEX, x0, y1, u0, v1, 0, 1'b1);
            pen_now = clamp16(nxt);
          end
        end
      end
    endcase
  endtask

  task automatic send_item(input text_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_item(it);
    in_tuser  <= it.kind;
    do @(posedge clk); while (!in_tready);
    lay_out(it);
    items_sent++;
  endtask

  task automatic load_glyph(input logic [7:0] code, input int bx, input int by,
                            input int w, input int h, input int adv, input int ax,
                            input int ay);
    text_item_t it;
    it      = random_item();
    it.kind = KIND_LOAD;
    it.code = code;
    it.bx   = 11'(bx);
    it.by   = 11'(by);
    it.w    = 8'(w);
    it.h    = 8'(h);
    it.adv  = 8'(adv);
    it.ax   = 12'(ax);
    it.ay   = 12'(ay);
    send_item(it);
  endtask

  task automatic load_random_glyph(input logic [7:0] code);
    text_item_t it;
    it      = random_item();
    it.kind = KIND_LOAD;
    it.code = code;
    if ($urandom_range(1)) it.adv = 8'($urandom_range(24));
    if ($urandom_range(4) == 0) it.ax = 12'(4095 - $urandom_range(40));
    if ($urandom_range(4) == 0) it.ay = 12'(4095 - $urandom_range(40));
    send_item(it);
  endtask

  task automatic begin_string(input int px, input int py, input int clip);
    text_item_t it;
    it      = random_item();
    it.kind = KIND_START;
    it.px   = 16'(px);
    it.py   = 16'(py);
    it.clip = 15'(clip);
    send_item(it);
  endtask

  task automatic end_string();
    text_item_t it;
    it      = random_item();
    it.kind = KIND_END;
    send_item(it);
  endtask

  // a slot is always filled before any byte that maps to it
  task automatic send_char(input logic [7:0] c);
    text_item_t it;
    if (!slot_loaded[slot_of(c)]) load_random_glyph(8'(slot_of(c)));
    it      = random_item();
    it.kind = KIND_CHAR;
    it.code = c;
    send_item(it);
  endtask

  task automatic write_font_size(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    font_px = int'(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait for the block to empty out
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic test_reset_state();
    end_string();
    load_glyph(8'd0, -1024, 1023, 255, 255, 255, 4095, 4095);
    send_char(8'h00);
    end_string();
  endtask

  task automatic test_slot_mapping();
    load_glyph(8'd1, 1023, -1024, 0, 0, 0, 0, 0);
    load_glyph(8'd95, -5, 10, 20, 30, 12, 4000, 100);
    load_glyph(8'd96, 7, 7, 7, 7, 7, 7, 7);
    load_glyph(8'd255, 9, 9, 9, 9, 9, 9, 9);
    begin_string(100, 200, 0);
    send_char(8'h00);
    send_char(8'h1F);
    send_char(8'h20);
    send_char(8'h7E);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(BLANK_BYTE);
    end_string();
  endtask

  task automatic test_saturation();
    begin_string(32700, -32768, 0);
    send_char(8'h00);
    send_char(8'h7E);
    end_string();
    begin_string(-32768, 32767, 0);
    send_char(8'h00);
    send_char(8'h20);
    end_string();
  endtask

  task automatic test_clipping();
    // slot 95 advances 12: 12 and 24 fit, 36 passes the limit
    begin_string(0, 0, 24);
    send_char(8'h7E);
    send_char(8'h7E);
    send_char(8'h7E);
    send_char(8'h20);
    send_char(BLANK_BYTE);
    end_string();
  endtask

  task automatic send_noise();
    text_item_t it;
    it = random_item();
    if (it.kind == KIND_CHAR) send_char(it.code);
    else send_item(it);
  endtask

  task automatic send_string();
    int r, px, py, clip, nchar;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 10) px = 32767 - int'($urandom_range(300));
    else if (r < 20) px = -32768 + int'($urandom_range(300));
    else if (r < 35) px = $signed(16'($urandom));
    else px = int'($urandom_range(3000)) - 500;
    r = $urandom_range(99);
    if (r < 10) py = 32767 - int'($urandom_range(200));
    else if (r < 20) py = -32768 + int'($urandom_range(200));
    else py = $signed(16'($urandom));
    r = $urandom_range(99);
    if (r < 50) clip = 0;
    else if (r < 85) clip = (px < 0) ? int'($urandom_range(150))
                                     : px + int'($urandom_range(150));
    else clip = int'($urandom_range(32767));
    if (clip > 32767) clip = 32767;
    begin_string(px, py, clip);
    nchar = $urandom_range(1, 8);
    repeat (nchar) begin
      r = $urandom_range(99);
      if (r < 8) load_random_glyph(8'($urandom_range(255)));
      if (r < 70) c = 8'($urandom_range(8'h20, 8'h7E));
      else if (r < 80) c = BLANK_BYTE;
      else c = 8'($urandom_range(255));
      send_char(c);
    end
    if ($urandom_range(9) != 0) end_string();
  endtask

  task automatic test_random_strings(input int send_idle, input int recv_stall,
                                     input logic [7:0] font, input int n_items);
    int stop_at;
    settle();
    write_font_size(font);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_string();
    end
  endtask

  // receiver holds off while characters keep coming, so in_tready has to drop
  task automatic test_backpressure();
    settle();
    idle_pct        = 0;
    stall_pct       = 0;
    hold_off_cycles = 300;
    begin_string(10, 20, 0);
    repeat (20) send_char(8'($urandom_range(8'h20, 8'h7E)));
    end_string();
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    vertex_beat_t got;
    vertex_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.vx   = out_tdata[15:0];
      got.vy   = out_tdata[31:16];
      got.tx   = out_tdata[43:32];
      got.ty   = out_tdata[55:44];
      got.dw   = out_tdata[71:56];
      got.last = out_tlast;
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", out_tdata, '0);
      end else begin
        want = pending_beats.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("result kind", 72'(got.kind), 72'(want.kind));
        if (got.vx !== want.vx) report_mismatch("vertex x", 72'(got.vx), 72'(want.vx));
        if (got.vy !== want.vy) report_mismatch("vertex y", 72'(got.vy), 72'(want.vy));
        if (got.tx !== want.tx) report_mismatch("tex x", 72'(got.tx), 72'(want.tx));
        if (got.ty !== want.ty) report_mismatch("tex y", 72'(got.ty), 72'(want.ty));
        if (got.dw !== want.dw)
          report_mismatch("drawn width", 72'(got.dw), 72'(want.dw));
        if (got.last !== want.last)
          report_mismatch("tlast", 72'(got.last), 72'(want.last));
      end
    end
  end

  initial begin
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = KIND_LOAD;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    err_count       = 0;
    items_sent      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_off_cycles = 0;
    pen_now         = 0;
    pen_base        = 0;
    pen_origin      = 0;
    clip_at         = 0;
    clipped         = 1'b0;
    font_px         = 0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    wait (rst_n === 1'b1);
    test_reset_state();
    settle();
    write_font_size(8'd9);
    test_slot_mapping();
    test_saturation();
    test_clipping();
    test_random_strings(0, 0, 8'd255, 60);
    test_random_strings(83, 0, 8'd0, 50);
    test_random_strings(0, 83, 8'($urandom_range(255)), 50);
    test_random_strings(33, 33, 8'($urandom_range(255)), 50);
    test_backpressure();
    settle();
    if (pending_beats.size() != 0)
      report_mismatch("beats never seen", 72'(pending_beats.size()), '0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* glyph_quad_text_layout.f */
+incdir+rtl
rtl/gqtl_pkg.sv
rtl/gqtl_front.sv
rtl/gqtl_queue.sv
rtl/gqtl_back.sv
rtl/glyph_quad_text_layout.sv
tb/glyph_quad_text_layout_tb.sv
